@@ design/mtbs_pkg.sv @@
// mtbs_pkg: constants, types and helper functions for the three-band splitter
// depends on nothing; used by mtbs_regs and multirate_three_band_splitter
`default_nettype none
package mtbs_pkg;

	localparam int FACTOR     = 4;
	localparam int DEC_HALF   = 13;
	localparam int KER_HALF   = 96;
	localparam int INT_TAPS   = 7;
	localparam int BANK_SIZE  = 48;
	localparam int CHANNELS   = 2;

	localparam int IN_LEN     = 2 * DEC_HALF + 1;
	localparam int DEC_LEN    = 2 * KER_HALF + 1;
	localparam int KTAPS      = KER_HALF + 1;
	localparam int DLY_LEN    = 2 * DEC_HALF + FACTOR * KER_HALF;
	localparam int DEC_COEFS  = DEC_HALF + 1;
	localparam int INT_COEFS  = FACTOR * INT_TAPS;
	localparam int BANK_COEFS = BANK_SIZE * KTAPS;

	// history memory layout, one block per channel
	localparam int H_IN       = 0;
	localparam int H_DEC      = H_IN + IN_LEN;
	localparam int H_LOW      = H_DEC + DEC_LEN;
	localparam int H_CHR      = H_LOW + INT_TAPS;
	localparam int H_DLY      = H_CHR + INT_TAPS;
	localparam int CH_SPAN    = H_DLY + DLY_LEN;
	localparam int HIST_DEPTH = CHANNELS * CH_SPAN;
	localparam int HA_W       = $clog2(HIST_DEPTH);

	// coefficient memory layout
	localparam int C_DEC      = 0;
	localparam int C_INT      = C_DEC + DEC_COEFS;
	localparam int C_BANK     = C_INT + INT_COEFS;
	localparam int C_CHR      = C_BANK + BANK_COEFS;
	localparam int COEF_DEPTH = C_CHR + KTAPS;
	localparam int CA_W       = $clog2(COEF_DEPTH);

	localparam int IP_W  = $clog2(IN_LEN);
	localparam int DP_W  = $clog2(DEC_LEN);
	localparam int TP_W  = $clog2(INT_TAPS);
	localparam int LP_W  = $clog2(DLY_LEN);
	localparam int PH_W  = $clog2(FACTOR);
	localparam int TAP_W = $clog2(KTAPS);
	localparam int ACC_W = 60;
	localparam int PA_W  = 3;

	localparam int POS_MAX = (BANK_SIZE - 1) * 256;
	localparam int BI_MAX  = BANK_SIZE - 2;

	localparam logic signed [ACC_W-1:0] S24_MAX = ACC_W'(8388607);
	localparam logic signed [ACC_W-1:0] S24_MIN = -ACC_W'(8388608);

	typedef enum logic [1:0] {
		TS_DEC  = 2'd0,
		TS_INT  = 2'd1,
		TS_BANK = 2'd2,
		TS_CHR  = 2'd3
	} tsel_t;

	typedef enum logic {
		KIND_AUDIO = 1'b0,
		KIND_COEF  = 1'b1
	} kind_t;

	typedef enum logic {
		REG_CH_COUNT = 1'b0,
		REG_XOVER    = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEC_RD,
		ST_DEC_MAC,
		ST_DEC_END,
		ST_KER_RD,
		ST_KER_BL,
		ST_KER_MAC,
		ST_KER_END,
		ST_KER_END2,
		ST_INT_RD,
		ST_INT_MAC,
		ST_INT_END,
		ST_DLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  channel_count;
		logic [13:0] crossover_position;
	} cfg_t;

	function automatic int wrap_add(input int a, input int b, input int len);
		int s;
		s = a + b;
		return (s >= len) ? s - len : s;
	endfunction

	function automatic int ring_back(input int pos, input int len);
		return (pos == 0) ? len - 1 : pos - 1;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
		if (v > S24_MAX)
			return 24'sh7fffff;
		else if (v < S24_MIN)
			return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic logic signed [23:0] round_sat16(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = (v + (ACC_W'(1) <<< 15)) >>> 16;
		return sat24(t);
	endfunction

	function automatic logic signed [23:0] round_sat24(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = (v + (ACC_W'(1) <<< 23)) >>> 24;
		return sat24(t);
	endfunction

endpackage
`default_nettype wire

@@ design/mtbs_regs.sv @@
// mtbs_regs: configuration register file behind an apb-style port
// depends on mtbs_pkg
`default_nettype none
module mtbs_regs (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [mtbs_pkg::PA_W-1:0] paddr,
	input  wire logic [31:0]             pwdata,
	output logic      [31:0]             prdata,
	output logic                         pready,
	output mtbs_pkg::cfg_t               cfg
);

	mtbs_pkg::cfg_t     cfg_q;
	mtbs_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = mtbs_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count      <= 2'd1;
			cfg_q.crossover_position <= '0;
		end else if (wr_en) begin
			case (idx)
				mtbs_pkg::REG_CH_COUNT: cfg_q.channel_count      <= pwdata[1:0];
				mtbs_pkg::REG_XOVER:    cfg_q.crossover_position <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mtbs_pkg::REG_CH_COUNT: prdata = {30'd0, cfg_q.channel_count};
			mtbs_pkg::REG_XOVER:    prdata = {18'd0, cfg_q.crossover_position};
			default:                prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ design/multirate_three_band_splitter.sv @@
// multirate_three_band_splitter: one multiply-accumulate sequencer over a history memory
// and a coefficient memory, both with registered reads; depends on mtbs_pkg, mtbs_regs
// on phase 0 a word runs the decimator, kernel and interpolator passes,
// on phases 1..3 only the interpolator pass
// throughput: one word at a time, next word accepted once the result is in the output register
// reset: all control clears at once; then a clearing pass zeroes all 1288 history memory
// entries, during which no word is accepted (configuration writes are taken)
`default_nettype none
module multirate_three_band_splitter (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      kind,
	input  wire logic                      channel,
	input  wire logic signed [23:0]        sample,
	input  wire logic [1:0]                table_select,
	input  wire logic [12:0]               coef_index,
	input  wire logic signed [17:0]        coef_value,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [23:0]             low_band,
	output logic signed [23:0]             mid_band,
	output logic signed [23:0]             upper_band,
	output logic                           out_channel,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [mtbs_pkg::PA_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready
);

	localparam int HA_W  = mtbs_pkg::HA_W;
	localparam int CA_W  = mtbs_pkg::CA_W;
	localparam int ACC_W = mtbs_pkg::ACC_W;

	mtbs_pkg::cfg_t cfg;

	mtbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// memories
	logic signed [23:0] hist_mem [mtbs_pkg::HIST_DEPTH];
	logic signed [17:0] coef_mem [mtbs_pkg::COEF_DEPTH];

	logic                   hist_we;
	logic [HA_W-1:0]        hist_wa, ra, rb;
	logic signed [23:0]     hist_wd;
	logic signed [23:0]     hra_q, hrb_q;
	logic                   coef_we;
	logic [CA_W-1:0]        coef_wa, ca, cb;
	logic signed [17:0]     cra_q, crb_q;

	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[hist_wa] <= hist_wd;
		hra_q <= hist_mem[ra];
		hrb_q <= hist_mem[rb];
	end

	always_ff @(posedge clk) begin
		if (coef_we)
			coef_mem[coef_wa] <= coef_value;
		cra_q <= coef_mem[ca];
		crb_q <= coef_mem[cb];
	end

	// control state
	mtbs_pkg::state_t         state_q, state_d;
	logic [HA_W-1:0]          clr_q;
	logic [mtbs_pkg::TAP_W-1:0] tap_q;
	logic                     ch_q;
	logic [mtbs_pkg::IP_W-1:0] inpos_q [mtbs_pkg::CHANNELS];
	logic [mtbs_pkg::DP_W-1:0] decpos_q [mtbs_pkg::CHANNELS];
	logic [mtbs_pkg::TP_W-1:0] itpos_q [mtbs_pkg::CHANNELS];
	logic [mtbs_pkg::LP_W-1:0] dlpos_q [mtbs_pkg::CHANNELS];
	logic [mtbs_pkg::PH_W-1:0] phase_q [mtbs_pkg::CHANNELS];
	logic                     out_valid_q;

	// datapath registers
	logic signed [23:0]       x_q;
	logic [8:0]               f_q;
	logic [CA_W-1:0]          kbase_q;
	logic signed [ACC_W-1:0]  acc_q, lacc_q, cacc_q;
	logic signed [24:0]       w_q;
	logic signed [28:0]       blend_q;
	logic signed [23:0]       lowp_q, charp_q, dly_q;
	logic signed [23:0]       low_q, mid_q, up_q;
	logic                     och_q;

	// handshake
	logic in_fire, audio_go, coef_go, out_load;
	assign in_stall  = (state_q != mtbs_pkg::ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign audio_go  = in_fire && (mtbs_pkg::kind_t'(kind) == mtbs_pkg::KIND_AUDIO) &&
		(2'(channel) < cfg.channel_count);
	assign coef_go   = in_fire && (mtbs_pkg::kind_t'(kind) == mtbs_pkg::KIND_COEF);

	assign out_valid   = out_valid_q;
	assign low_band    = low_q;
	assign mid_band    = mid_q;
	assign upper_band  = up_q;
	assign out_channel = och_q;

	// address arithmetic
	int chb, chb_in, tapi;
	int new_in, new_dec, new_it;
	logic [13:0] pos_c;
	logic [5:0]  bi_c;
	logic [8:0]  f_c;

	always_comb begin
		chb    = ch_q ? mtbs_pkg::CH_SPAN : 0;
		chb_in = channel ? mtbs_pkg::CH_SPAN : 0;
		tapi   = int'(tap_q);
		new_in  = mtbs_pkg::ring_back(int'(inpos_q[channel]), mtbs_pkg::IN_LEN);
		new_dec = mtbs_pkg::ring_back(int'(decpos_q[ch_q]), mtbs_pkg::DEC_LEN);
		new_it  = mtbs_pkg::ring_back(int'(itpos_q[ch_q]), mtbs_pkg::INT_TAPS);
		pos_c  = (int'(cfg.crossover_position) > mtbs_pkg::POS_MAX) ?
			14'(mtbs_pkg::POS_MAX) : cfg.crossover_position;
		bi_c   = (int'(pos_c[13:8]) > mtbs_pkg::BI_MAX) ? 6'(mtbs_pkg::BI_MAX) : pos_c[13:8];
		f_c    = 9'(int'(pos_c) - int'(bi_c) * 256);
	end

	// arithmetic
	logic signed [24:0] w_d;
	logic signed [18:0] diff;
	logic signed [9:0]  fx;
	logic signed [28:0] fprod, lo_ext, blend_d;
	logic signed [42:0] prod_a, prod_b;
	logic signed [53:0] prod_l;

	always_comb begin
		w_d = 25'(hra_q);
		if ((state_q == mtbs_pkg::ST_DEC_MAC) && (tapi != mtbs_pkg::DEC_HALF))
			w_d = 25'(hra_q) + 25'(hrb_q);
		else if ((state_q == mtbs_pkg::ST_KER_BL) && (tapi != mtbs_pkg::KER_HALF))
			w_d = 25'(hra_q) + 25'(hrb_q);
		diff    = 19'(crb_q) - 19'(cra_q);
		fx      = $signed({1'b0, f_q});
		fprod   = fx * diff;
		lo_ext  = 29'(cra_q);
		blend_d = (lo_ext <<< 8) + fprod;
		if (state_q == mtbs_pkg::ST_INT_MAC) begin
			prod_a = cra_q * hra_q;
			prod_b = cra_q * hrb_q;
		end else begin
			prod_a = cra_q * w_d;
			prod_b = cra_q * w_q;
		end
		prod_l = blend_q * w_q;
	end

	// sequencer: next state and memory controls
	always_comb begin
		state_d  = state_q;
		hist_we  = 1'b0;
		hist_wa  = '0;
		hist_wd  = '0;
		ra       = '0;
		rb       = '0;
		ca       = '0;
		cb       = '0;
		coef_we  = 1'b0;
		coef_wa  = '0;
		out_load = 1'b0;
		case (mtbs_pkg::tsel_t'(table_select))
			mtbs_pkg::TS_DEC: begin
				coef_we = coef_go && (int'(coef_index) < mtbs_pkg::DEC_COEFS);
				coef_wa = CA_W'(mtbs_pkg::C_DEC + int'(coef_index));
			end
			mtbs_pkg::TS_INT: begin
				coef_we = coef_go && (int'(coef_index) < mtbs_pkg::INT_COEFS);
				coef_wa = CA_W'(mtbs_pkg::C_INT + int'(coef_index));
			end
			mtbs_pkg::TS_BANK: begin
				coef_we = coef_go && (int'(coef_index) < mtbs_pkg::BANK_COEFS);
				coef_wa = CA_W'(mtbs_pkg::C_BANK + int'(coef_index));
			end
			mtbs_pkg::TS_CHR: begin
				coef_we = coef_go && (int'(coef_index) < mtbs_pkg::KTAPS);
				coef_wa = CA_W'(mtbs_pkg::C_CHR + int'(coef_index));
			end
			default: coef_we = 1'b0;
		endcase
		case (state_q)
			mtbs_pkg::ST_CLEAR: begin
				hist_we = 1'b1;
				hist_wa = clr_q;
				if (int'(clr_q) == mtbs_pkg::HIST_DEPTH - 1)
					state_d = mtbs_pkg::ST_IDLE;
			end
			mtbs_pkg::ST_IDLE: begin
				if (audio_go) begin
					hist_we = 1'b1;
					hist_wa = HA_W'(chb_in + mtbs_pkg::H_IN + new_in);
					hist_wd = sample;
					state_d = (phase_q[channel] == '0) ? mtbs_pkg::ST_DEC_RD :
						mtbs_pkg::ST_INT_RD;
				end
			end
			mtbs_pkg::ST_DEC_RD: begin
				ra = HA_W'(chb + mtbs_pkg::H_IN +
					mtbs_pkg::wrap_add(int'(inpos_q[ch_q]), tapi, mtbs_pkg::IN_LEN));
				rb = HA_W'(chb + mtbs_pkg::H_IN + mtbs_pkg::wrap_add(int'(inpos_q[ch_q]),
					2 * mtbs_pkg::DEC_HALF - tapi, mtbs_pkg::IN_LEN));
				ca = CA_W'(mtbs_pkg::C_DEC + tapi);
				state_d = mtbs_pkg::ST_DEC_MAC;
			end
			mtbs_pkg::ST_DEC_MAC: begin
				state_d = (tapi == mtbs_pkg::DEC_HALF) ? mtbs_pkg::ST_DEC_END :
					mtbs_pkg::ST_DEC_RD;
			end
			mtbs_pkg::ST_DEC_END: begin
				hist_we = 1'b1;
				hist_wa = HA_W'(chb + mtbs_pkg::H_DEC + new_dec);
				hist_wd = mtbs_pkg::round_sat16(acc_q);
				state_d = mtbs_pkg::ST_KER_RD;
			end
			mtbs_pkg::ST_KER_RD: begin
				ra = HA_W'(chb + mtbs_pkg::H_DEC +
					mtbs_pkg::wrap_add(int'(decpos_q[ch_q]), tapi, mtbs_pkg::DEC_LEN));
				rb = HA_W'(chb + mtbs_pkg::H_DEC + mtbs_pkg::wrap_add(int'(decpos_q[ch_q]),
					2 * mtbs_pkg::KER_HALF - tapi, mtbs_pkg::DEC_LEN));
				ca = CA_W'(mtbs_pkg::C_BANK + int'(kbase_q) + tapi);
				cb = CA_W'(mtbs_pkg::C_BANK + int'(kbase_q) + mtbs_pkg::KTAPS + tapi);
				state_d = mtbs_pkg::ST_KER_BL;
			end
			mtbs_pkg::ST_KER_BL: begin
				ca = CA_W'(mtbs_pkg::C_CHR + tapi);
				state_d = mtbs_pkg::ST_KER_MAC;
			end
			mtbs_pkg::ST_KER_MAC: begin
				state_d = (tapi == mtbs_pkg::KER_HALF) ? mtbs_pkg::ST_KER_END :
					mtbs_pkg::ST_KER_RD;
			end
			mtbs_pkg::ST_KER_END: begin
				hist_we = 1'b1;
				hist_wa = HA_W'(chb + mtbs_pkg::H_LOW + new_it);
				hist_wd = mtbs_pkg::round_sat24(lacc_q);
				state_d = mtbs_pkg::ST_KER_END2;
			end
			mtbs_pkg::ST_KER_END2: begin
				hist_we = 1'b1;
				hist_wa = HA_W'(chb + mtbs_pkg::H_CHR + int'(itpos_q[ch_q]));
				hist_wd = mtbs_pkg::round_sat16(cacc_q);
				state_d = mtbs_pkg::ST_INT_RD;
			end
			mtbs_pkg::ST_INT_RD: begin
				ra = HA_W'(chb + mtbs_pkg::H_LOW +
					mtbs_pkg::wrap_add(int'(itpos_q[ch_q]), tapi, mtbs_pkg::INT_TAPS));
				rb = HA_W'(chb + mtbs_pkg::H_CHR +
					mtbs_pkg::wrap_add(int'(itpos_q[ch_q]), tapi, mtbs_pkg::INT_TAPS));
				ca = CA_W'(mtbs_pkg::C_INT + int'(phase_q[ch_q]) * mtbs_pkg::INT_TAPS + tapi);
				state_d = mtbs_pkg::ST_INT_MAC;
			end
			mtbs_pkg::ST_INT_MAC: begin
				state_d = (tapi == mtbs_pkg::INT_TAPS - 1) ? mtbs_pkg::ST_INT_END :
					mtbs_pkg::ST_INT_RD;
			end
			mtbs_pkg::ST_INT_END: begin
				ra = HA_W'(chb + mtbs_pkg::H_DLY + int'(dlpos_q[ch_q]));
				state_d = mtbs_pkg::ST_DLY;
			end
			mtbs_pkg::ST_DLY: begin
				hist_we = 1'b1;
				hist_wa = HA_W'(chb + mtbs_pkg::H_DLY + int'(dlpos_q[ch_q]));
				hist_wd = x_q;
				state_d = mtbs_pkg::ST_DONE;
			end
			mtbs_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = mtbs_pkg::ST_IDLE;
				end
			end
			default: state_d = mtbs_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtbs_pkg::ST_CLEAR;
			clr_q       <= '0;
			tap_q       <= '0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < mtbs_pkg::CHANNELS; c++) begin
				inpos_q[c]  <= '0;
				decpos_q[c] <= '0;
				itpos_q[c]  <= '0;
				dlpos_q[c]  <= '0;
				phase_q[c]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				mtbs_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				mtbs_pkg::ST_IDLE: begin
					tap_q <= '0;
					if (audio_go) begin
						ch_q <= channel;
						inpos_q[channel] <= mtbs_pkg::IP_W'(new_in);
					end
				end
				mtbs_pkg::ST_DEC_MAC, mtbs_pkg::ST_KER_MAC, mtbs_pkg::ST_INT_MAC: begin
					if (state_d == mtbs_pkg::ST_DEC_RD || state_d == mtbs_pkg::ST_KER_RD ||
						state_d == mtbs_pkg::ST_INT_RD)
						tap_q <= tap_q + 1'b1;
					else
						tap_q <= '0;
				end
				mtbs_pkg::ST_DEC_END: decpos_q[ch_q] <= mtbs_pkg::DP_W'(new_dec);
				mtbs_pkg::ST_KER_END: itpos_q[ch_q] <= mtbs_pkg::TP_W'(new_it);
				mtbs_pkg::ST_INT_END: begin
					phase_q[ch_q] <= (int'(phase_q[ch_q]) + 1 >= mtbs_pkg::FACTOR) ? '0 :
						phase_q[ch_q] + 1'b1;
				end
				mtbs_pkg::ST_DLY: begin
					dlpos_q[ch_q] <= (int'(dlpos_q[ch_q]) + 1 >= mtbs_pkg::DLY_LEN) ? '0 :
						dlpos_q[ch_q] + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			mtbs_pkg::ST_IDLE: begin
				x_q     <= sample;
				f_q     <= f_c;
				kbase_q <= CA_W'(int'(bi_c) * mtbs_pkg::KTAPS);
				acc_q   <= '0;
				lacc_q  <= '0;
				cacc_q  <= '0;
			end
			mtbs_pkg::ST_DEC_MAC: acc_q <= acc_q + ACC_W'(prod_a);
			mtbs_pkg::ST_KER_BL: begin
				w_q     <= w_d;
				blend_q <= blend_d;
			end
			mtbs_pkg::ST_KER_MAC: begin
				lacc_q <= lacc_q + ACC_W'(prod_l);
				cacc_q <= cacc_q + ACC_W'(prod_b);
			end
			mtbs_pkg::ST_KER_END2: begin
				lacc_q <= '0;
				cacc_q <= '0;
			end
			mtbs_pkg::ST_INT_MAC: begin
				lacc_q <= lacc_q + ACC_W'(prod_a);
				cacc_q <= cacc_q + ACC_W'(prod_b);
			end
			mtbs_pkg::ST_INT_END: begin
				lowp_q  <= mtbs_pkg::round_sat16(lacc_q);
				charp_q <= mtbs_pkg::round_sat16(cacc_q);
			end
			mtbs_pkg::ST_DLY: dly_q <= hra_q;
			default: ;
		endcase
		if (out_load) begin
			low_q <= lowp_q;
			mid_q <= mtbs_pkg::sat24(ACC_W'(charp_q) - ACC_W'(lowp_q));
			up_q  <= mtbs_pkg::sat24(ACC_W'(dly_q) - ACC_W'(charp_q));
			och_q <= ch_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mtbs_pkg::ST_DONE))
		else $error("result word appeared outside the finishing step");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtbs_pkg::ST_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished word not loaded into empty output register");

	a_dec_tap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtbs_pkg::ST_DEC_MAC) |-> (int'(tap_q) <= mtbs_pkg::DEC_HALF))
		else $error("decimator tap counter overran");

	a_in_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtbs_pkg::ST_DEC_RD) |-> (int'(inpos_q[ch_q]) < mtbs_pkg::IN_LEN))
		else $error("input ring position out of range");
`endif

endmodule
`default_nettype wire

@@ bench/multirate_three_band_splitter_test.sv @@
// testbench for multirate_three_band_splitter: bursty word source, stalling result sink,
// apb register writes between phases and a word-by-word band predictor
// depends on mtbs_pkg and the design files
`default_nettype none
module multirate_three_band_splitter_test;

	localparam int PA_W       = mtbs_pkg::PA_W;
	localparam int IN_LEN     = mtbs_pkg::IN_LEN;
	localparam int DEC_LEN    = mtbs_pkg::DEC_LEN;
	localparam int INT_TAPS   = mtbs_pkg::INT_TAPS;
	localparam int DLY_LEN    = mtbs_pkg::DLY_LEN;
	localparam int DEC_COEFS  = mtbs_pkg::DEC_COEFS;
	localparam int INT_COEFS  = mtbs_pkg::INT_COEFS;
	localparam int BANK_COEFS = mtbs_pkg::BANK_COEFS;
	localparam int KTAPS      = mtbs_pkg::KTAPS;
	localparam int DEC_HALF   = mtbs_pkg::DEC_HALF;
	localparam int KER_HALF   = mtbs_pkg::KER_HALF;
	localparam int POS_MAX    = mtbs_pkg::POS_MAX;
	localparam int BI_MAX     = mtbs_pkg::BI_MAX;
	localparam int FACTOR     = mtbs_pkg::FACTOR;

	typedef struct packed {
		logic        kind;
		logic        channel;
		logic [23:0] sample;
		logic [1:0]  tsel;
		logic [12:0] cidx;
		logic [17:0] cval;
	} word_t;

	typedef struct packed {
		logic [23:0] lo;
		logic [23:0] mid;
		logic [23:0] up;
		logic        ch;
	} bands_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic kind = 0, channel = 0;
	logic signed [23:0] sample = 0;
	logic [1:0] table_select = 0;
	logic [12:0] coef_index = 0;
	logic signed [17:0] coef_value = 0;
	logic signed [23:0] low_band, mid_band, upper_band;
	logic out_channel;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [PA_W-1:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;

	multirate_three_band_splitter dut (.*);

	initial forever #5 clk = ~clk;

	// predictor state
	int unsigned m_chcount, m_xover;
	longint in_h[2][IN_LEN], dec_h[2][DEC_LEN], low_h[2][INT_TAPS], chr_h[2][INT_TAPS];
	longint dly[2][DLY_LEN];
	int in_p[2], dec_p[2], int_p[2], dly_p[2], ph[2];
	longint dec_c[DEC_COEFS], int_c[INT_COEFS], bank_c[BANK_COEFS], chr_c[KTAPS];

	word_t pending[$];
	bands_t expected_bands[$];
	int errors = 0;
	longint cycles = 0;
	bit pause_src = 0;

	function automatic longint clamp24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic longint rshift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic int wadd(int a, int b, int len);
		return (a + b >= len) ? a + b - len : a + b;
	endfunction

	function automatic int back(int p, int len);
		return p == 0 ? len - 1 : p - 1;
	endfunction

	task automatic predict_bands(word_t w);
		int c, p, bi, f, pos, base;
		longint x, acc, lacc, cacc, lo, hi, wv, lowp, charp, delayed;
		bands_t r;
		c = w.channel;
		x = longint'($signed(w.sample));
		if (w.kind == mtbs_pkg::KIND_COEF) begin
			case (mtbs_pkg::tsel_t'(w.tsel))
				mtbs_pkg::TS_DEC:  if (w.cidx < DEC_COEFS) dec_c[w.cidx] = $signed(w.cval);
				mtbs_pkg::TS_INT:  if (w.cidx < INT_COEFS) int_c[w.cidx] = $signed(w.cval);
				mtbs_pkg::TS_BANK: if (w.cidx < BANK_COEFS) bank_c[w.cidx] = $signed(w.cval);
				default: if (w.cidx < KTAPS) chr_c[w.cidx] = $signed(w.cval);
			endcase
			return;
		end
		if (c >= m_chcount) return;
		in_p[c] = back(in_p[c], IN_LEN);
		in_h[c][in_p[c]] = x;
		if (ph[c] == 0) begin
			p = in_p[c];
			acc = dec_c[DEC_HALF] * in_h[c][wadd(p, DEC_HALF, IN_LEN)];
			for (int j = 0; j < DEC_HALF; j++)
				acc += dec_c[j] * (in_h[c][wadd(p, j, IN_LEN)]
					+ in_h[c][wadd(p, 2 * DEC_HALF - j, IN_LEN)]);
			dec_p[c] = back(dec_p[c], DEC_LEN);
			dec_h[c][dec_p[c]] = clamp24(rshift(acc, 16));
			p = dec_p[c];
			pos = m_xover > POS_MAX ? POS_MAX : m_xover;
			bi = pos >> 8;
			if (bi > BI_MAX) bi = BI_MAX;
			f = pos - bi * 256;
			lacc = 0;
			cacc = 0;
			for (int j = 0; j <= KER_HALF; j++) begin
				lo = bank_c[bi * KTAPS + j];
				hi = bank_c[(bi + 1) * KTAPS + j];
				if (j == KER_HALF) wv = dec_h[c][wadd(p, KER_HALF, DEC_LEN)];
				else wv = dec_h[c][wadd(p, j, DEC_LEN)]
					+ dec_h[c][wadd(p, 2 * KER_HALF - j, DEC_LEN)];
				lacc += (lo * 256 + f * (hi - lo)) * wv;
				cacc += chr_c[j] * wv;
			end
			int_p[c] = back(int_p[c], INT_TAPS);
			low_h[c][int_p[c]] = clamp24(rshift(lacc, 24));
			chr_h[c][int_p[c]] = clamp24(rshift(cacc, 16));
		end
		p = int_p[c];
		base = ph[c] * INT_TAPS;
		lacc = 0;
		cacc = 0;
		for (int j = 0; j < INT_TAPS; j++) begin
			lacc += int_c[base + j] * low_h[c][wadd(p, j, INT_TAPS)];
			cacc += int_c[base + j] * chr_h[c][wadd(p, j, INT_TAPS)];
		end
		lowp = clamp24(rshift(lacc, 16));
		charp = clamp24(rshift(cacc, 16));
		ph[c] = (ph[c] + 1 >= FACTOR) ? 0 : ph[c] + 1;
		delayed = dly[c][dly_p[c]];
		dly[c][dly_p[c]] = x;
		dly_p[c] = (dly_p[c] + 1 >= DLY_LEN) ? 0 : dly_p[c] + 1;
		r.lo = lowp[23:0];
		r.mid = 24'(clamp24(charp - lowp));
		r.up = 24'(clamp24(delayed - charp));
		r.ch = c[0];
		expected_bands.push_back(r);
	endtask

	// driver: bursts and gaps
	int gap = 0, burst = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_bands(pending.pop_front());
		end
		if (!(in_valid && in_stall)) begin
			if (burst == 0 && gap == 0) begin
				burst = $urandom_range(1, 20);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			end
			if (gap > 0) begin
				gap--;
				in_valid <= 1'b0;
			end else if (pending.size() > 0 && !pause_src && arst_n) begin
				burst--;
				in_valid <= 1'b1;
				{kind, channel, sample, table_select, coef_index, coef_value} <= pending[0];
			end else
				in_valid <= 1'b0;
		end
	end

	// monitor and sink stall pattern
	int stall_mode = 0;
	always @(posedge clk) begin
		bands_t e;
		cycles++;
		if (cycles > 64'd4000000) begin
			$display("TEST FAILED");
			$finish;
		end
		if (out_valid && !out_stall) begin
			if (expected_bands.size() == 0) begin
				$display("%0t unexpected result ch %0d", $time, out_channel);
				errors++;
			end else begin
				e = expected_bands.pop_front();
				if (e.lo !== low_band || e.mid !== mid_band || e.up !== upper_band ||
						e.ch !== out_channel) begin
					$display("%0t mismatch expected lo %0d mid %0d up %0d ch %0d",
						$time, $signed(e.lo), $signed(e.mid), $signed(e.up), e.ch);
					$display("%0t          actual   lo %0d mid %0d up %0d ch %0d",
						$time, low_band, mid_band, upper_band, out_channel);
					errors++;
				end
			end
		end
		if (cycles % 500 == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic reg_write(int idx, int unsigned val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= PA_W'(4 * idx); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == mtbs_pkg::REG_CH_COUNT) m_chcount = val & 3;
		else m_xover = val & 16'h3fff;
	endtask

	task automatic drain();
		while (pending.size() > 0 || expected_bands.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic word_t coef_word(int ts, int idx, int val);
		word_t w;
		w = '0;
		w.kind = mtbs_pkg::KIND_COEF;
		w.tsel = 2'(ts);
		w.cidx = 13'(idx);
		w.cval = 18'(val);
		return w;
	endfunction

	function automatic word_t audio_word(int c, int s);
		word_t w;
		w = '0;
		w.kind = mtbs_pkg::KIND_AUDIO;
		w.channel = 1'(c);
		w.sample = 24'(s);
		w.tsel = 2'($urandom);
		w.cidx = 13'($urandom);
		w.cval = 18'($urandom);
		return w;
	endfunction

	function automatic int rnd_coef();
		case ($urandom_range(0, 5))
			0: return 131071;
			1: return -131072;
			default: return $signed(18'($urandom)) >>> $urandom_range(0, 8);
		endcase
	endfunction

	function automatic int rnd_sample();
		case ($urandom_range(0, 7))
			0: return 8388607;
			1: return -8388608;
			default: return $signed(24'($urandom));
		endcase
	endfunction

	// only the bank kernels that the crossover settings below select
	task automatic load_tables();
		int kern[6] = '{0, 1, 23, 24, 46, 47};
		for (int i = 0; i < DEC_COEFS; i++)
			pending.push_back(coef_word(mtbs_pkg::TS_DEC, i, rnd_coef()));
		for (int i = 0; i < INT_COEFS; i++)
			pending.push_back(coef_word(mtbs_pkg::TS_INT, i, rnd_coef()));
		for (int k = 0; k < 6; k++)
			for (int i = 0; i < KTAPS; i++)
				pending.push_back(coef_word(mtbs_pkg::TS_BANK, kern[k] * KTAPS + i,
					rnd_coef()));
		for (int i = 0; i < KTAPS; i++)
			pending.push_back(coef_word(mtbs_pkg::TS_CHR, i, rnd_coef()));
	endtask

	task automatic audio_run(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 30) == 0)
				pending.push_back(coef_word($urandom_range(0, 3), $urandom_range(0, 8191),
					rnd_coef()));
			else
				pending.push_back(audio_word($urandom_range(0, 1), rnd_sample()));
		end
	endtask

	int xsets[6] = '{0, 12032, 16383, 255, 11776, 6000};

	initial begin
		m_chcount = 1;
		m_xover = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		load_tables();
		// directed: extremes, both channels, out-of-range index
		pending.push_back(coef_word(mtbs_pkg::TS_CHR, 8191, 5));
		pending.push_back(coef_word(mtbs_pkg::TS_DEC, DEC_COEFS, 5));
		pending.push_back(audio_word(0, 8388607));
		pending.push_back(audio_word(0, -8388608));
		pending.push_back(audio_word(1, 1234));
		pending.push_back(audio_word(0, -1));
		pending.push_back(audio_word(1, 0));
		drain();
		reg_write(mtbs_pkg::REG_CH_COUNT, 2);
		reg_write(mtbs_pkg::REG_XOVER, 16383);
		for (int i = 0; i < 12; i++)
			pending.push_back(audio_word(i % 2, (i % 3 == 0) ? 8388607 : -8388608));
		drain();
		for (int k = 0; k < 6; k++) begin
			reg_write(mtbs_pkg::REG_CH_COUNT, (k == 3) ? 1 : ((k == 4) ? 0 : 2));
			reg_write(mtbs_pkg::REG_XOVER, xsets[k]);
			audio_run(170);
			if (k == 2) begin
				while (pending.size() > 140) @(posedge clk);
				pause_src = 1;
				while (expected_bands.size() > 0) @(posedge clk);
				pause_src = 0;
			end
			drain();
		end
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
